// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator.
// Holds sizes, codes, state encoding and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none
package ffba_pkg;
	localparam int HEAP_BYTES   = 1048576;
	localparam int ALIGN        = 16;
	localparam int HEADER_BYTES = 32;
	localparam int MAX_BLOCKS   = 64;
	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int ADDR_W = 20;
	localparam int SIZE_W = 21;
	localparam int NEED_W = SIZE_W + 1;
	localparam int TOP_W  = 25;
	localparam int ALIGN_W = $clog2(ALIGN);

	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_FREE   = 2'd1;
	localparam logic [1:0] CMD_RESIZE = 2'd2;

	localparam logic [1:0] MODE_UNUSED = 2'd0;
	localparam logic [1:0] MODE_ALLOC  = 2'd1;
	localparam logic [1:0] MODE_FREE   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OOM     = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_DOUBLE  = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SCAN, S_SCAN_WAIT, S_ALLOC_DECIDE,
		S_REUSE, S_BUMP, S_RELEASE, S_RESIZE_CHK, S_RANK, S_RANK_WAIT, S_OUT
	} state_t;

	typedef enum logic [1:0] {
		SCAN_FIT, SCAN_ADDR, SCAN_RANK
	} scan_kind_t;

	typedef struct packed {
		logic       load_req;
		logic       scan_start;
		scan_kind_t scan_kind;
		logic       do_reuse;
		logic       do_bump;
		logic       do_release;
		logic       set_result;
		logic [1:0] res_status;
		logic       res_from_grant;
		logic       res_from_addr;
	} ctrl_t;

	typedef struct packed {
		logic       scan_busy;
		logic       fit_found;
		logic       alloc_found;
		logic       free_found;
		logic       slot_found;
		logic       bump_room;
		logic       grows;
		logic [1:0] cmd;
		logic       addr_zero;
		logic       size_zero;
	} stat_t;
endpackage
`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator: heap address allocator with a 64-entry block table.
// Each table pass reads one entry per cycle.
// Bump allocation or a failed lookup takes one table pass before the result.
// Free or reuse adds a recency pass; a growing resize takes an address, a fit and a recency pass.
// Trivial requests need no table pass; the block takes one request at a time.
// Reset clears top offset and all entry modes at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_block_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // cmd[1:0], req_size[22:2], req_addr[42:23]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata   // grant_addr[19:0], status[21:20]
);
	import ffba_pkg::*;

	ctrl_t       ctrl;
	stat_t       stat;
	logic [19:0] grant_addr;
	logic [1:0]  status;

	ffba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .ctrl(ctrl), .stat(stat)
	);

	ffba_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.in_cmd(s_tdata[1:0]), .in_size(s_tdata[22:2]), .in_addr(s_tdata[42:23]),
		.grant_addr(grant_addr), .status(status)
	);

	assign m_tdata = {2'b00, status, grant_addr};
endmodule
`default_nettype wire

// ===== rtl/ffba_datapath.sv =====
// ----------------------------------------------------------------------------
// ffba_datapath: block table, sequential scan unit and result register.
// Scans one entry per cycle: newest freed fit, address match or rank update.
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ffba_pkg::ctrl_t ctrl,
	output ffba_pkg::stat_t      stat,
	input  wire logic [1:0]     in_cmd,
	input  wire logic [20:0]    in_size,
	input  wire logic [19:0]    in_addr,
	output logic [19:0]         grant_addr,
	output logic [1:0]          status
);
	import ffba_pkg::*;

	logic [ADDR_W-1:0] addr_mem [MAX_BLOCKS];
	logic [SIZE_W-1:0] size_mem [MAX_BLOCKS];
	logic [IDX_W-1:0]  rank_mem [MAX_BLOCKS];
	logic [1:0]        mode_q   [MAX_BLOCKS];

	logic [1:0]        cmd_q;
	logic [SIZE_W-1:0] size_q;
	logic [NEED_W-1:0] need_q;
	logic [ADDR_W-1:0] addr_q;
	logic [TOP_W-1:0]  top_q;

	logic [CNT_W-1:0]  ptr_q;
	logic              busy_q;
	logic              rd_v_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [SIZE_W-1:0] rd_size_q;
	logic [IDX_W-1:0]  rd_rank_q;
	logic [1:0]        rd_mode_q;
	scan_kind_t        kind_q;

	logic              fit_q, alloc_q, free_q, slot_q;
	logic [IDX_W-1:0]  fit_idx_q, alloc_idx_q, slot_idx_q;
	logic [IDX_W-1:0]  fit_rank_q;
	logic [ADDR_W-1:0] fit_addr_q;
	logic [SIZE_W-1:0] alloc_size_q;
	logic              pend_reuse_q, pend_release_q;

	logic [TOP_W-1:0]  bump_end;
	logic [SIZE_W+ALIGN_W-1:0] need_sum;
	logic [NEED_W-1:0] need_c;
	logic [ADDR_W-1:0] grant_q;
	logic              rank_clear;
	logic              rank_dec;
	logic              rank_inc;

	assign need_sum = {{ALIGN_W{1'b0}}, in_size} + (SIZE_W+ALIGN_W)'(ALIGN - 1);
	assign need_c = (in_size == '0) ? NEED_W'(ALIGN) :
		NEED_W'({need_sum[SIZE_W+ALIGN_W-1:ALIGN_W], {ALIGN_W{1'b0}}});
	assign bump_end = top_q + TOP_W'(HEADER_BYTES) + TOP_W'(need_q);
	assign rank_clear = (pend_reuse_q && rd_idx_q == fit_idx_q) ||
		(pend_release_q && rd_idx_q == alloc_idx_q);
	assign rank_dec = pend_reuse_q && rd_rank_q > fit_rank_q;
	assign rank_inc = pend_release_q;

	always_ff @(posedge clk) begin
		if (ctrl.load_req) begin
			cmd_q  <= in_cmd;
			size_q <= in_size;
			need_q <= need_c;
			addr_q <= in_addr;
		end
		rd_addr_q <= addr_mem[ptr_q[IDX_W-1:0]];
		rd_size_q <= size_mem[ptr_q[IDX_W-1:0]];
		rd_rank_q <= rank_mem[ptr_q[IDX_W-1:0]];
		if (ctrl.do_bump && !ctrl.do_reuse) begin
			addr_mem[slot_idx_q] <= ADDR_W'(top_q + TOP_W'(HEADER_BYTES));
			size_mem[slot_idx_q] <= SIZE_W'(need_q);
		end
		if (rd_v_q && kind_q == SCAN_RANK) begin
			if (rank_clear)
				rank_mem[rd_idx_q] <= '0;
			else if (rd_mode_q == MODE_FREE)
				rank_mem[rd_idx_q] <= rd_rank_q - {{(IDX_W-1){1'b0}}, rank_dec} +
					{{(IDX_W-1){1'b0}}, rank_inc};
		end
		if (ctrl.do_reuse)
			grant_q <= fit_addr_q;
		else if (ctrl.do_bump)
			grant_q <= ADDR_W'(top_q + TOP_W'(HEADER_BYTES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			busy_q <= 1'b0;
			rd_v_q <= 1'b0;
			ptr_q <= '0;
			rd_idx_q <= '0;
			rd_mode_q <= MODE_UNUSED;
			kind_q <= SCAN_FIT;
			fit_q <= 1'b0; alloc_q <= 1'b0; free_q <= 1'b0; slot_q <= 1'b0;
			fit_idx_q <= '0; alloc_idx_q <= '0; slot_idx_q <= '0;
			fit_rank_q <= '0; fit_addr_q <= '0; alloc_size_q <= '0;
			pend_reuse_q <= 1'b0; pend_release_q <= 1'b0;
			grant_addr <= '0;
			status <= ST_OK;
			for (int i = 0; i < MAX_BLOCKS; i++)
				mode_q[i] <= MODE_UNUSED;
		end else begin
			rd_v_q <= busy_q;
			rd_idx_q <= ptr_q[IDX_W-1:0];
			rd_mode_q <= mode_q[ptr_q[IDX_W-1:0]];
			if (ctrl.load_req) begin
				pend_reuse_q <= 1'b0;
				pend_release_q <= 1'b0;
			end
			if (ctrl.scan_start) begin
				busy_q <= 1'b1;
				ptr_q <= '0;
				kind_q <= ctrl.scan_kind;
				fit_q <= 1'b0; alloc_q <= 1'b0; free_q <= 1'b0; slot_q <= 1'b0;
			end else if (busy_q) begin
				if (ptr_q == CNT_W'(MAX_BLOCKS - 1))
					busy_q <= 1'b0;
				ptr_q <= ptr_q + 1'b1;
			end
			if (rd_v_q) begin
				if (rd_mode_q == MODE_UNUSED && !slot_q) begin
					slot_q <= 1'b1;
					slot_idx_q <= rd_idx_q;
				end
				if (kind_q == SCAN_FIT) begin
					if (rd_mode_q == MODE_FREE && {1'b0, rd_size_q} >= need_q &&
							(!fit_q || rd_rank_q < fit_rank_q)) begin
						fit_q <= 1'b1;
						fit_idx_q <= rd_idx_q;
						fit_rank_q <= rd_rank_q;
						fit_addr_q <= rd_addr_q;
					end
				end else if (kind_q == SCAN_ADDR) begin
					if (rd_mode_q == MODE_ALLOC && rd_addr_q == addr_q && !alloc_q) begin
						alloc_q <= 1'b1;
						alloc_idx_q <= rd_idx_q;
						alloc_size_q <= rd_size_q;
					end
					if (rd_mode_q == MODE_FREE && rd_addr_q == addr_q)
						free_q <= 1'b1;
				end
			end
			if (ctrl.do_reuse) begin
				mode_q[fit_idx_q] <= MODE_ALLOC;
				pend_reuse_q <= 1'b1;
			end else if (ctrl.do_bump) begin
				mode_q[slot_idx_q] <= MODE_ALLOC;
				top_q <= bump_end;
			end
			if (ctrl.do_release) begin
				mode_q[alloc_idx_q] <= MODE_FREE;
				pend_release_q <= 1'b1;
			end
			if (ctrl.set_result) begin
				status <= ctrl.res_status;
				grant_addr <= ctrl.res_from_grant ? grant_q :
					ctrl.res_from_addr ? addr_q : '0;
			end
		end
	end

	assign stat.scan_busy   = busy_q | rd_v_q | ctrl.scan_start;
	assign stat.fit_found   = fit_q;
	assign stat.alloc_found = alloc_q;
	assign stat.free_found  = free_q;
	assign stat.slot_found  = slot_q;
	assign stat.bump_room   = bump_end < TOP_W'(HEAP_BYTES);
	assign stat.grows       = need_q > {1'b0, alloc_size_q};
	assign stat.cmd         = cmd_q;
	assign stat.addr_zero   = addr_q == '0;
	assign stat.size_zero   = size_q == '0;
endmodule
`default_nettype wire

// ===== rtl/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl: request sequencer of the allocator.
// Orders scans, table updates and the result beat for each request.
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output ffba_pkg::ctrl_t      ctrl,
	input  wire ffba_pkg::stat_t stat
);
	import ffba_pkg::*;

	state_t state_q, state_d;
	logic   resize_q, resize_d;
	logic   out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			resize_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			resize_q <= resize_d;
			if (ctrl.set_result)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
		end
	end

	assign m_tvalid = out_v_q;
	assign s_tready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		resize_d = resize_q;
		ctrl = '0;
		ctrl.scan_kind = SCAN_FIT;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					ctrl.load_req = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				resize_d = 1'b0;
				case (stat.cmd)
					CMD_ALLOC: begin
						ctrl.scan_start = 1'b1;
						state_d = S_SCAN;
					end
					CMD_FREE: begin
						if (stat.addr_zero) begin
							state_d = S_OUT;
						end else begin
							ctrl.scan_start = 1'b1;
							ctrl.scan_kind = SCAN_ADDR;
							state_d = S_SCAN;
						end
					end
					CMD_RESIZE: begin
						if (stat.addr_zero) begin
							ctrl.scan_start = 1'b1;
							state_d = S_SCAN;
						end else if (stat.size_zero) begin
							ctrl.res_from_addr = 1'b1;
							state_d = S_OUT;
						end else begin
							ctrl.scan_start = 1'b1;
							ctrl.scan_kind = SCAN_ADDR;
							resize_d = 1'b1;
							state_d = S_SCAN;
						end
					end
					default: state_d = S_OUT;
				endcase
				if (state_d == S_OUT && !out_v_q) begin
					ctrl.set_result = 1'b1;
					ctrl.res_status = ST_OK;
					state_d = S_IDLE;
				end else if (state_d == S_OUT) begin
					state_d = stat.size_zero && stat.cmd == CMD_RESIZE && !stat.addr_zero
						? S_RESIZE_CHK : S_OUT;
				end
			end
			S_SCAN: begin
				state_d = S_SCAN_WAIT;
			end
			S_SCAN_WAIT: begin
				if (!stat.scan_busy) begin
					if (stat.cmd == CMD_FREE)
						state_d = S_RELEASE;
					else if (stat.cmd == CMD_RESIZE && !stat.addr_zero && resize_q)
						state_d = S_RESIZE_CHK;
					else
						state_d = S_ALLOC_DECIDE;
				end
			end
			S_RESIZE_CHK: begin
				if (!out_v_q) begin
					if (!resize_q) begin
						ctrl.set_result = 1'b1;
						ctrl.res_from_addr = 1'b1;
						state_d = S_IDLE;
					end else if (!stat.alloc_found) begin
						ctrl.set_result = 1'b1;
						ctrl.res_status = ST_INVALID;
						state_d = S_IDLE;
					end else if (!stat.grows) begin
						ctrl.set_result = 1'b1;
						ctrl.res_from_addr = 1'b1;
						state_d = S_IDLE;
					end else begin
						resize_d = 1'b0;
						ctrl.scan_start = 1'b1;
						state_d = S_SCAN;
					end
				end
			end
			S_ALLOC_DECIDE: begin
				if (stat.fit_found)
					state_d = S_REUSE;
				else if (stat.bump_room && stat.slot_found)
					state_d = S_BUMP;
				else if (!out_v_q) begin
					ctrl.set_result = 1'b1;
					ctrl.res_status = ST_OOM;
					state_d = S_IDLE;
				end
			end
			S_REUSE, S_BUMP: begin
				ctrl.do_reuse = state_q == S_REUSE;
				ctrl.do_bump = 1'b1;
				if (stat.cmd == CMD_RESIZE && !stat.addr_zero)
					state_d = S_RELEASE;
				else
					state_d = (state_q == S_REUSE) ? S_RANK : S_OUT;
			end
			S_RELEASE: begin
				if (stat.cmd == CMD_RESIZE || stat.alloc_found) begin
					ctrl.do_release = 1'b1;
					state_d = S_RANK;
				end else if (!out_v_q) begin
					ctrl.set_result = 1'b1;
					ctrl.res_status = stat.free_found ? ST_DOUBLE : ST_INVALID;
					state_d = S_IDLE;
				end
			end
			S_RANK: begin
				ctrl.scan_start = 1'b1;
				ctrl.scan_kind = SCAN_RANK;
				state_d = S_RANK_WAIT;
			end
			S_RANK_WAIT: begin
				if (!stat.scan_busy)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_v_q) begin
					ctrl.set_result = 1'b1;
					ctrl.res_from_grant = stat.cmd == CMD_ALLOC || stat.cmd == CMD_RESIZE;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== test/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_checker: result checker for the first-fit block allocator.
// Watches both streams, keeps its own copy of the block table, predicts the
// result of every accepted request and compares each returned beat with it.
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [47:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [23:0] m_tdata,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ffba_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0] grant;
		logic [1:0]        status;
	} grant_t;

	logic [ADDR_W-1:0] tbl_addr [MAX_BLOCKS];
	logic [SIZE_W-1:0] tbl_size [MAX_BLOCKS];
	logic [1:0]        tbl_mode [MAX_BLOCKS];
	int                tbl_rank [MAX_BLOCKS];
	longint            heap_top;
	grant_t            grants_due [$];

	function automatic longint rounded(logic [SIZE_W-1:0] n);
		if (n == 0)
			return ALIGN;
		return ((longint'(n) + ALIGN - 1) / ALIGN) * ALIGN;
	endfunction

	function automatic int lookup(logic [ADDR_W-1:0] a, logic [1:0] m);
		for (int i = 0; i < MAX_BLOCKS; i++)
			if (tbl_mode[i] == m && tbl_addr[i] == a)
				return i;
		return -1;
	endfunction

	task automatic mark_free(int idx);
		for (int i = 0; i < MAX_BLOCKS; i++)
			if (tbl_mode[i] == MODE_FREE)
				tbl_rank[i]++;
		tbl_mode[idx] = MODE_FREE;
		tbl_rank[idx] = 0;
	endtask

	task automatic take_block(longint need, output logic [ADDR_W-1:0] g,
			output logic [1:0] st);
		int best;
		int slot;
		int r;
		best = -1;
		slot = -1;
		for (int i = 0; i < MAX_BLOCKS; i++)
			if (tbl_mode[i] == MODE_FREE && tbl_size[i] >= need)
				if (best < 0 || tbl_rank[i] < tbl_rank[best])
					best = i;
		if (best >= 0) begin
			r = tbl_rank[best];
			for (int i = 0; i < MAX_BLOCKS; i++)
				if (tbl_mode[i] == MODE_FREE && tbl_rank[i] > r)
					tbl_rank[i]--;
			tbl_mode[best] = MODE_ALLOC;
			tbl_rank[best] = 0;
			st = ST_OK;
			g = tbl_addr[best];
			return;
		end
		g = '0;
		st = ST_OOM;
		if (heap_top + HEADER_BYTES + need >= HEAP_BYTES)
			return;
		for (int i = 0; i < MAX_BLOCKS; i++)
			if (tbl_mode[i] == MODE_UNUSED) begin
				slot = i;
				break;
			end
		if (slot < 0)
			return;
		tbl_addr[slot] = ADDR_W'(heap_top + HEADER_BYTES);
		tbl_size[slot] = SIZE_W'(need);
		tbl_mode[slot] = MODE_ALLOC;
		tbl_rank[slot] = 0;
		heap_top = heap_top + HEADER_BYTES + need;
		st = ST_OK;
		g = tbl_addr[slot];
	endtask

	task automatic predict(logic [47:0] d);
		logic [1:0]        cmd;
		logic [SIZE_W-1:0] sz;
		logic [ADDR_W-1:0] a;
		grant_t            e;
		int                idx;
		cmd = d[1:0];
		sz = d[22:2];
		a = d[42:23];
		e = '{grant: '0, status: ST_OK};
		if (cmd == CMD_ALLOC || (cmd == CMD_RESIZE && a == 0)) begin
			take_block(rounded(sz), e.grant, e.status);
		end else if (cmd == CMD_FREE) begin
			if (a != 0) begin
				idx = lookup(a, MODE_ALLOC);
				if (idx >= 0)
					mark_free(idx);
				else if (lookup(a, MODE_FREE) >= 0)
					e.status = ST_DOUBLE;
				else
					e.status = ST_INVALID;
			end
		end else if (cmd == CMD_RESIZE) begin
			if (sz == 0) begin
				e.grant = a;
			end else begin
				idx = lookup(a, MODE_ALLOC);
				if (idx < 0)
					e.status = ST_INVALID;
				else if (rounded(sz) <= tbl_size[idx])
					e.grant = a;
				else begin
					take_block(rounded(sz), e.grant, e.status);
					if (e.status == ST_OK)
						mark_free(idx);
				end
			end
		end
		grants_due.push_back(e);
	endtask

	assign pending = grants_due.size();

	initial begin
		fail_count = 0;
		heap_top = 0;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			tbl_mode[i] = MODE_UNUSED;
			tbl_rank[i] = 0;
			tbl_addr[i] = '0;
			tbl_size[i] = '0;
		end
	end

	always @(posedge clk) begin
		grant_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict(s_tdata);
			if (m_tvalid && m_tready) begin
				if (grants_due.size() == 0) begin
					$error("unexpected result beat %h", m_tdata);
					fail_count++;
				end else begin
					e = grants_due.pop_front();
					if (m_tdata[19:0] !== e.grant) begin
						$error("grant_addr expected %h actual %h", e.grant, m_tdata[19:0]);
						fail_count++;
					end
					if (m_tdata[21:20] !== e.status) begin
						$error("status expected %0d actual %0d", e.status, m_tdata[21:20]);
						fail_count++;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the first-fit block allocator.
// Drives directed and random alloc, free, resize, bad requests in bursts, with
// a stalling receiver and one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ffba_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	int          fail_count;
	int          pending;
	logic        hold_off;
	logic [ADDR_W-1:0] handed [$];

	first_fit_block_allocator u_top (.*);

	ffba_checker u_chk (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk)
		if (m_tvalid && m_tready && m_tdata[19:0] != 0 && handed.size() < 200)
			handed.push_back(m_tdata[19:0]);

	function automatic logic [47:0] pack(logic [1:0] cmd, logic [SIZE_W-1:0] sz,
			logic [ADDR_W-1:0] a);
		return {5'b0, a, sz, cmd};
	endfunction

	task automatic send(logic [47:0] d);
		s_tdata <= d;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic gap();
		int len;
		len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : 0;
		if (len != 0) begin
			s_tvalid <= 1'b0;
			repeat (len) @(posedge clk);
		end
	endtask

	function automatic logic [ADDR_W-1:0] known_addr();
		if (handed.size() == 0 || $urandom_range(0, 9) == 0)
			return ADDR_W'($urandom);
		return handed[$urandom_range(0, handed.size() - 1)] +
			($urandom_range(0, 15) == 0 ? ADDR_W'(ALIGN) : '0);
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		case ($urandom_range(0, 9))
			0: return SIZE_W'($urandom);
			1: return SIZE_W'($urandom_range(0, 1048576));
			2: return '0;
			default: return SIZE_W'($urandom_range(1, 2000));
		endcase
	endfunction

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off)
				m_tready <= 1'b0;
			else case ($urandom_range(0, 3))
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= $urandom_range(0, 1);
				default: m_tready <= ($urandom_range(0, 19) == 0);
			endcase
		end
	end

	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		repeat (3000) @(posedge clk);
		hold_off <= 1'b1;
		repeat (2000) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int burst;
		int waited;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(pack(CMD_FREE, 0, 0));
		send(pack(CMD_RESIZE, 0, 20'hFFFFF));
		send(pack(CMD_ALLOC, 0, 0));
		send(pack(CMD_ALLOC, 1, 0));
		send(pack(CMD_ALLOC, 21'h1FFFFF, 20'hFFFFF));
		send(pack(CMD_ALLOC, 1048576, 0));
		send(pack(CMD_ALLOC, 1048576 - 64, 0));
		send(pack(CMD_FREE, 0, 20'h00020));
		send(pack(CMD_FREE, 0, 20'h00020));
		send(pack(CMD_FREE, 0, 20'hFFFFF));
		send(pack(CMD_ALLOC, 10, 0));
		send(pack(CMD_RESIZE, 5, 20'h00020));
		send(pack(CMD_RESIZE, 100, 20'h00020));
		send(pack(CMD_RESIZE, 100, 20'h00070));
		send(pack(CMD_RESIZE, 0, 0));
		send(pack(CMD_RESIZE, 3000, 0));
		send(pack(2'd3, 21'h1FFFFF, 20'hFFFFF));
		send(pack(CMD_RESIZE, 21'h1FFFFF, 20'h00020));
		gap();

		for (int n = 0; n < 540; ) begin
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst; k++, n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: send(pack(CMD_ALLOC, rand_size(), ADDR_W'($urandom)));
					4, 5, 6: send(pack(CMD_FREE, SIZE_W'($urandom), known_addr()));
					7, 8: send(pack(CMD_RESIZE, rand_size(),
						$urandom_range(0, 7) == 0 ? '0 : known_addr()));
					default: send(pack(2'($urandom), SIZE_W'($urandom), ADDR_W'($urandom)));
				endcase
			end
			gap();
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

// ===== first_fit_block_allocator.f =====
rtl/ffba_pkg.sv
rtl/ffba_datapath.sv
rtl/ffba_ctrl.sv
rtl/first_fit_block_allocator.sv
test/ffba_checker.sv
test/tb.sv
